// ===== design/ems_page_mapper_assert.svh =====
// ----------------------------------------------------------------------------
// ems_page_mapper_assert.svh
// Assertion macros used by the page mapper datapath.
// ----------------------------------------------------------------------------
`ifndef EMS_PAGE_MAPPER_ASSERT_SVH
`define EMS_PAGE_MAPPER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define EMSPM_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define EMSPM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/emspm_pkg.sv =====
// ----------------------------------------------------------------------------
// emspm_pkg
// Types and constants shared by the page mapper controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emspm_pkg;

  localparam int REG_COUNT    = 256;
  localparam int PAGE_WINDOWS = 4;

  // Access kinds
  localparam logic [1:0] MODE_IO_RD = 2'd0;
  localparam logic [1:0] MODE_IO_WR = 2'd1;
  localparam logic [1:0] MODE_XLATE = 2'd2;

  // Decoded ports and chipset registers
  localparam logic [15:0] IDX_PORT    = 16'h0022;
  localparam logic [15:0] DATA_PORT   = 16'h0023;
  localparam logic [7:0]  REG_EMS_CFG = 8'h4C;
  localparam logic [7:0]  REG_CLOCK   = 8'h40;

  localparam logic [13:0] PORT_BASE_FIXED   = 14'h0208;
  // Frame base and RAM start counted in 16 KB units
  localparam logic [5:0]  FRAME_UNIT_RESET  = 6'h30;
  localparam logic [7:0]  EMS_RAM_UNIT      = 8'd40;
  localparam logic [6:0]  FRAME_UNITS       = 7'd4;
  localparam logic [7:0]  UNDECODED_DATA    = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_PAGE_COUNT = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic capture;  // take the input item, start the register file read
    logic exec;     // update state and load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_ready;  // output register free or being emptied
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/emspm_ctrl.sv =====
// ----------------------------------------------------------------------------
// emspm_ctrl
// Sequencer: takes one item, then executes it once the output slot is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emspm_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_valid_i,
  output logic                        s_ready_o,
  input  wire emspm_pkg::dp_status_t  status_i,
  output emspm_pkg::ctrl_cmd_t        cmd_o
);
  import emspm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.out_ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o     = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = status_i.out_ready;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/emspm_dp.sv =====
// ----------------------------------------------------------------------------
// emspm_dp
// Datapath: item register, chipset register file, page registers, decode,
// address translation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ems_page_mapper_assert.svh"

module emspm_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire emspm_pkg::ctrl_cmd_t  cmd_i,
  output emspm_pkg::dp_status_t      status_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [19:0]           access_addr_i,
  input  wire logic [7:0]            write_data_i,
  input  wire logic [7:0]            page_count_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 read_data_o,
  output logic                       port_hit_o,
  output logic                       frame_hit_o,
  output logic [21:0]                phys_addr_o,
  output logic                       turbo_o
);
  import emspm_pkg::*;

  // Held item
  logic [1:0]  mode_q;
  logic [19:0] addr_q;
  logic [7:0]  wdata_q;

  // Architectural state
  logic [7:0]  index_q, index_d;
  logic [7:0]  pages_q [PAGE_WINDOWS];
  logic [3:0]  port_sel_q;
  logic [3:0]  frame_sel_q;
  logic        turbo_q, turbo_d;

  // Register file and its written marks
  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] written_q;
  logic [7:0]           mem_rd_q;
  logic                 written_rd_q;

  // Output register
  logic        out_valid_q;
  logic [7:0]  rdata_q, rdata_d;
  logic        phit_q, phit_d;
  logic        fhit_q, fhit_d;
  logic [21:0] phys_q, phys_d;
  logic        turbo_out_q;

  // Decode
  logic [15:0] port;
  logic        is_idx, is_data, ems_hit;
  logic [1:0]  win;
  logic [5:0]  unit, frame_unit;
  logic [6:0]  frame_end;
  logic        in_frame;
  logic [1:0]  pg;
  logic [7:0]  page;
  logic        page_en;
  logic [7:0]  mem_rd;

  logic        wr_cmd, idx_we, reg_we, cfg_we, clk_we, page_we;

  assign status_o.out_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      addr_q  <= access_addr_i;
      wdata_q <= write_data_i;
    end
  end

  assign port    = addr_q[15:0];
  assign is_idx  = (port == IDX_PORT);
  assign is_data = (port == DATA_PORT);
  assign ems_hit = (port[13:0] == (PORT_BASE_FIXED | {6'b0, port_sel_q, 4'b0}));
  // Address bits 14 and 15 swapped give the window
  assign win     = {port[14], port[15]};

  assign unit       = addr_q[19:14];
  assign frame_unit = FRAME_UNIT_RESET + {2'b0, frame_sel_q};
  assign frame_end  = {1'b0, frame_unit} + FRAME_UNITS;
  assign in_frame   = (unit >= frame_unit) && ({1'b0, unit} < frame_end);
  assign pg         = 2'(unit - frame_unit);
  assign page       = pages_q[pg];
  assign page_en    = page[7] && ({1'b0, page[6:0]} < page_count_i);

  assign mem_rd = written_rd_q ? mem_rd_q : 8'h00;

  assign wr_cmd  = cmd_i.exec && (mode_q == MODE_IO_WR);
  assign idx_we  = wr_cmd && is_idx;
  assign reg_we  = wr_cmd && is_data;
  assign cfg_we  = reg_we && (index_q == REG_EMS_CFG);
  assign clk_we  = reg_we && (index_q == REG_CLOCK);
  assign page_we = wr_cmd && !is_idx && !is_data && ems_hit;

  assign index_d = idx_we ? wdata_q : index_q;
  assign turbo_d = clk_we ? wdata_q[7] : turbo_q;

  // Read at the held index while the item is taken; written at execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mem_rd_q     <= mem[index_q];
      written_rd_q <= written_q[index_q];
    end
    if (reg_we) begin
      mem[index_q] <= wdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (reg_we) begin
      written_q[index_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q     <= '0;
      port_sel_q  <= '0;
      frame_sel_q <= '0;
      turbo_q     <= 1'b0;
      for (int i = 0; i < PAGE_WINDOWS; i++) pages_q[i] <= '0;
    end else begin
      index_q <= index_d;
      turbo_q <= turbo_d;
      if (cfg_we) begin
        port_sel_q  <= wdata_q[7:4];
        frame_sel_q <= wdata_q[3:0];
        for (int i = 0; i < PAGE_WINDOWS; i++) pages_q[i] <= '0;
      end else if (page_we) begin
        pages_q[win] <= wdata_q;
      end
    end
  end

  always_comb begin
    rdata_d = 8'h00;
    phit_d  = 1'b0;
    fhit_d  = 1'b0;
    phys_d  = '0;
    case (mode_q)
      MODE_IO_RD: begin
        if (is_idx) begin
          rdata_d = index_q;
          phit_d  = 1'b1;
        end else if (is_data) begin
          rdata_d = mem_rd;
          phit_d  = 1'b1;
        end else if (ems_hit) begin
          rdata_d = pages_q[win];
          phit_d  = 1'b1;
        end else begin
          rdata_d = UNDECODED_DATA;
        end
      end
      MODE_IO_WR: begin
        phit_d = is_idx || is_data || ems_hit;
      end
      MODE_XLATE: begin
        if (in_frame && page_en) begin
          fhit_d = 1'b1;
          phys_d = {8'(EMS_RAM_UNIT + {1'b0, page[6:0]}), addr_q[13:0]};
        end
      end
      default: begin
        rdata_d = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rdata_q     <= rdata_d;
      phit_q      <= phit_d;
      fhit_q      <= fhit_d;
      phys_q      <= phys_d;
      turbo_out_q <= turbo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign port_hit_o  = phit_q;
  assign frame_hit_o = fhit_q;
  assign phys_addr_o = phys_q;
  assign turbo_o     = turbo_out_q;

  `EMSPM_ASSERT(a_hits_exclusive, clk_i, rst_ni, out_valid_q |-> !(phit_q && fhit_q), "port and frame hit together")
  `EMSPM_ASSERT(a_phys_only_on_hit, clk_i, rst_ni, (out_valid_q && !fhit_q) |-> (phys_q == 22'd0), "address without frame hit")
  `EMSPM_ASSERT(a_cfg_clears_pages, clk_i, rst_ni, cfg_we |=> (pages_q[0] == 8'h00 && pages_q[1] == 8'h00 && pages_q[2] == 8'h00 && pages_q[3] == 8'h00), "pages not cleared")
  `EMSPM_ASSERT(a_exec_needs_slot, clk_i, rst_ni, cmd_i.exec |-> (!out_valid_q || out_ready_i), "output overwritten")

endmodule

`default_nettype wire

// ===== design/ems_page_mapper.sv =====
// ----------------------------------------------------------------------------
// ems_page_mapper
// Chipset register file with an EMS page mapper: I/O decode of the index,
// data and page ports, and translation of frame addresses to RAM addresses.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  mode, access_addr, write_data
//  m_axis   out  m_axis_tvalid/m_axis_tready  read_data, port_hit, frame_hit,
//                                             phys_addr, turbo
//  apb      in   psel/penable/pwrite/pready   ems_page_count at byte 0
//
//  Each item is first taken, with the register file read at the current
//  index, then executed: state is updated and the output register loaded.
//  The output register lets the next item be taken while a result waits.
//  A stalled output holds the block in execute until the result is taken.
//  Reset is asynchronous, active low; the register file reads as zero until
//  an entry is written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ems_page_mapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // s_axis_tdata: mode[1:0], access_addr[21:2], write_data[29:22], zero pad
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // m_axis_tdata: read_data[7:0], port_hit[8], frame_hit[9],
  //               phys_addr[31:10], turbo[32], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import emspm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [7:0]  page_count_q;
  logic        cfg_wr;

  logic [7:0]  read_data;
  logic        port_hit, frame_hit, turbo;
  logic [21:0] phys_addr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_PAGE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= '0;
    end else if (cfg_wr) begin
      page_count_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == CFG_PAGE_COUNT) ? {24'b0, page_count_q} : 32'b0;

  emspm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  emspm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (s_axis_tdata[1:0]),
    .access_addr_i (s_axis_tdata[21:2]),
    .write_data_i  (s_axis_tdata[29:22]),
    .page_count_i  (page_count_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .read_data_o   (read_data),
    .port_hit_o    (port_hit),
    .frame_hit_o   (frame_hit),
    .phys_addr_o   (phys_addr),
    .turbo_o       (turbo)
  );

  assign m_axis_tdata = {7'b0, turbo, phys_addr, frame_hit, port_hit, read_data};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus accesses into ems_page_mapper over the stream ports and checks
// every returned item against an in-bench model of the index and data ports,
// the register file, the EMS page registers and frame translation. The page
// count is written over the configuration port between phases. The phases
// run with no idling, with sender gaps, with receiver stalls and with both.
// ----------------------------------------------------------------------------
module testbench;
  import emspm_pkg::*;

  localparam logic [1:0] MODE_NONE       = 2'd3;
  localparam logic [2:0] PAGE_COUNT_ADDR = 3'(4 * CFG_PAGE_COUNT);
  localparam int unsigned PHASE_ITEMS    = 435;
  localparam int unsigned MAX_REPORTS    = 10;

  // Field order follows the stream layout, lowest bits last
  typedef struct packed {
    logic [7:0]  wdata;
    logic [19:0] addr;
    logic [1:0]  mode;
  } bus_access_t;

  typedef struct packed {
    logic        turbo;
    logic [21:0] phys_addr;
    logic        frame_hit;
    logic        port_hit;
    logic [7:0]  read_data;
  } bus_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // s_axis_tdata: mode[1:0], access_addr[21:2], write_data[29:22], zero pad
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // m_axis_tdata: read_data[7:0], port_hit[8], frame_hit[9], phys_addr[31:10],
  //               turbo[32], zero pad
  logic [39:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ems_page_mapper u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Chipset model
  logic [7:0]  chip_index = 8'h00;
  logic [7:0]  chip_regs [REG_COUNT] = '{default: 8'h00};
  logic [7:0]  page_slots [PAGE_WINDOWS] = '{default: 8'h00};
  logic [13:0] page_port_base = PORT_BASE_FIXED;
  logic [5:0]  frame_unit = FRAME_UNIT_RESET;
  logic        turbo_bit  = 1'b0;
  logic [7:0]  page_count = 8'h00;

  // Stimulus-side view of the layout, used only to aim accesses
  logic [13:0] aim_port_base  = PORT_BASE_FIXED;
  logic [5:0]  aim_frame_unit = FRAME_UNIT_RESET;

  bus_access_t pending_q [$];
  bus_result_t bus_result_q [$];
  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        s_taken = 1'b0;

  function automatic bus_result_t decode_access(input bus_access_t a);
    bus_result_t r;
    logic [15:0] port;
    logic        ems_hit;
    logic [1:0]  win;
    logic [1:0]  slot;
    logic [7:0]  pv;
    r = '0;
    port = a.addr[15:0];
    ems_hit = (port[13:0] == page_port_base);
    // page ports carry the window number with bits 14 and 15 swapped
    win = {port[14], port[15]};
    case (a.mode)
      MODE_IO_RD: begin
        r.read_data = UNDECODED_DATA;
        r.port_hit = 1'b1;
        if (port == IDX_PORT) r.read_data = chip_index;
        else if (port == DATA_PORT) r.read_data = chip_regs[chip_index];
        else if (ems_hit) r.read_data = page_slots[win];
        else r.port_hit = 1'b0;
      end
      MODE_IO_WR: begin
        r.port_hit = 1'b1;
        if (port == IDX_PORT) begin
          chip_index = a.wdata;
        end else if (port == DATA_PORT) begin
          chip_regs[chip_index] = a.wdata;
          if (chip_index == REG_EMS_CFG) begin
            page_port_base = PORT_BASE_FIXED | {6'b0, a.wdata[7:4], 4'b0};
            frame_unit = FRAME_UNIT_RESET + 6'(a.wdata[3:0]);
            foreach (page_slots[i]) page_slots[i] = 8'h00;
          end else if (chip_index == REG_CLOCK) begin
            turbo_bit = a.wdata[7];
          end
        end else if (ems_hit) begin
          page_slots[win] = a.wdata;
        end else begin
          r.port_hit = 1'b0;
        end
      end
      MODE_XLATE: begin
        // the frame never wraps: units above 0x3F are simply unreachable
        if (a.addr[19:14] >= frame_unit &&
            {1'b0, a.addr[19:14]} < {1'b0, frame_unit} + FRAME_UNITS) begin
          slot = a.addr[15:14] - frame_unit[1:0];
          pv = page_slots[slot];
          if (pv[7] && {1'b0, pv[6:0]} < page_count) begin
            r.frame_hit = 1'b1;
            r.phys_addr = {EMS_RAM_UNIT + {1'b0, pv[6:0]}, a.addr[13:0]};
          end
        end
      end
      default: ;
    endcase
    r.turbo = turbo_bit;
    return r;
  endfunction

  function automatic string fmt_result(input bus_result_t r);
    return $sformatf("rd=%02h port=%0d frame=%0d phys=%06h turbo=%0d",
                     r.read_data, r.port_hit, r.frame_hit, r.phys_addr, r.turbo);
  endfunction

  // Driver: hold an item until taken, then advance or idle
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || s_taken) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pending_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor first, then predict for the item taken at this edge
  always @(posedge clk_i) begin
    bus_result_t got;
    bus_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[32:0];
      if (bus_result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected item: %s", fmt_result(got));
      end else begin
        want = bus_result_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected %s, got %s", fmt_result(want), fmt_result(got));
        end
      end
    end
    s_taken = s_axis_tvalid && s_axis_tready;
    if (s_taken) begin
      bus_result_q.push_back(decode_access(s_axis_tdata[29:0]));
      accepted_total++;
    end
  end

  task automatic push_access(input logic [1:0] mode, input logic [19:0] addr,
                             input logic [7:0] data);
    pending_q.push_back({data, addr, mode});
    queued_total++;
  endtask

  // Index write then data write; high address bits are don't-care for I/O
  task automatic queue_index_data(input logic [7:0] idx, input logic [7:0] data);
    push_access(MODE_IO_WR, {4'($urandom), IDX_PORT}, idx);
    push_access(MODE_IO_WR, {4'($urandom), DATA_PORT}, data);
    if (idx == REG_EMS_CFG) begin
      aim_port_base = PORT_BASE_FIXED | {6'b0, data[7:4], 4'b0};
      aim_frame_unit = FRAME_UNIT_RESET + 6'(data[3:0]);
    end
  endtask

  // Random window in bits 15:14, random don't-care bits above the port
  function automatic logic [19:0] ems_port_addr();
    return {4'($urandom), 2'($urandom), aim_port_base};
  endfunction

  task automatic queue_random(input int unsigned n);
    int unsigned target;
    int unsigned pick;
    int unsigned sel;
    logic [7:0]  idx;
    logic [6:0]  num;
    logic [6:0]  unit;
    logic [13:0] offs;
    target = queued_total + n;
    while (queued_total < target) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        sel = $urandom_range(9);
        idx = (sel == 0) ? REG_EMS_CFG : (sel < 3) ? REG_CLOCK : 8'($urandom);
        queue_index_data(idx, 8'($urandom));
        if ($urandom_range(1) == 1)
          push_access(MODE_IO_RD, {4'($urandom), DATA_PORT}, 8'($urandom));
      end else if (pick < 35) begin
        if (page_count > 0 && $urandom_range(3) != 0)
          num = 7'($urandom_range(0, (page_count > 128) ? 127 : page_count - 1));
        else
          num = 7'($urandom);
        push_access(MODE_IO_WR, ems_port_addr(), {($urandom_range(9) != 0), num});
      end else if (pick < 70) begin
        unit = {1'b0, aim_frame_unit} + 7'($urandom_range(3));
        if (unit > 7'h3F) unit = 7'h3F;
        case ($urandom_range(3))
          0: offs = 14'h0000;
          1: offs = 14'h3FFF;
          default: offs = 14'($urandom);
        endcase
        push_access(MODE_XLATE, {unit[5:0], offs}, 8'($urandom));
      end else if (pick < 80) begin
        case ($urandom_range(2))
          0: push_access(MODE_IO_RD, {4'($urandom), IDX_PORT}, 8'($urandom));
          1: push_access(MODE_IO_RD, {4'($urandom), DATA_PORT}, 8'($urandom));
          default: push_access(MODE_IO_RD, ems_port_addr(), 8'($urandom));
        endcase
      end else if (pick < 85) begin
        push_access(MODE_XLATE, 20'($urandom), 8'($urandom));
      end else begin
        push_access(2'($urandom), 20'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == PAGE_COUNT_ADDR) page_count = data[7:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off until every queued item has been taken and answered
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_total != queued_total || bus_result_q.size() != 0);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic [7:0] count);
    apb_write(PAGE_COUNT_ADDR, {24'b0, count});
    @(posedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(PHASE_ITEMS);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_write(PAGE_COUNT_ADDR, 32'd128);
    @(posedge clk_i);
    push_access(MODE_IO_RD, 20'h00022, 8'h00);
    push_access(MODE_IO_RD, 20'h00023, 8'h00);
    push_access(MODE_IO_RD, 20'hFFFFF, 8'hFF);
    push_access(MODE_NONE, 20'hFFFFF, 8'hFF);
    queue_index_data(REG_CLOCK, 8'h80);
    push_access(MODE_IO_RD, 20'h00023, 8'h00);
    // move the page ports to 0x258 and the frame to 0xFC000, past 1 MB
    queue_index_data(REG_EMS_CFG, 8'h5F);
    push_access(MODE_IO_RD, 20'h00208, 8'h00);
    push_access(MODE_IO_WR, 20'h00258, 8'h80);
    push_access(MODE_IO_WR, 20'h08258, 8'hFF);
    push_access(MODE_IO_WR, 20'h04258, 8'h05);
    push_access(MODE_IO_WR, 20'h0C258, 8'h81);
    push_access(MODE_IO_RD, 20'h04258, 8'h00);
    push_access(MODE_XLATE, 20'hFC000, 8'h00);
    push_access(MODE_XLATE, 20'hFFFFF, 8'h00);
    push_access(MODE_XLATE, 20'hFBFFF, 8'h00);
    push_access(MODE_XLATE, 20'h00000, 8'h00);
    queue_index_data(REG_EMS_CFG, 8'h00);
    push_access(MODE_IO_WR, 20'h0C208, 8'hFF);
    push_access(MODE_XLATE, 20'hCFFFF, 8'h00);
    push_access(MODE_XLATE, 20'hC4000, 8'h00);
    queue_index_data(REG_CLOCK, 8'h7F);
    wait_drained();

    // page number equal to the count must not map
    apb_write(PAGE_COUNT_ADDR, 32'd127);
    @(posedge clk_i);
    push_access(MODE_XLATE, 20'hCFFFF, 8'h00);
    push_access(MODE_IO_WR, 20'h08208, 8'hFE);
    push_access(MODE_XLATE, 20'hC4123, 8'h00);
    wait_drained();

    run_phase(0, 0, 8'd128);
    run_phase(53, 0, 8'($urandom_range(1, 127)));
    run_phase(0, 53, 8'd0);
    run_phase(20, 20, 8'($urandom_range(0, 128)));

    repeat (8) @(posedge clk_i);
    if (bus_result_q.size() != 0)
      $display("expected items never returned: %0d", bus_result_q.size());
    if (mismatch_count == 0 && bus_result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/emspm_pkg.sv
design/emspm_ctrl.sv
design/emspm_dp.sv
design/ems_page_mapper.sv
tb/testbench.sv
